@@ rtl/tvu_pkg.sv @@
// Package with shared types and codes for the tile video unit.
`default_nettype none
package tvu_pkg;
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_WRITE  = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [2:0] REG_CTRL        = 3'd0;
   localparam logic [2:0] REG_MASK        = 3'd1;
   localparam logic [2:0] REG_STATUS      = 3'd2;
   localparam logic [2:0] REG_SPRITE_ADDR = 3'd3;
   localparam logic [2:0] REG_SPRITE_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL      = 3'd5;
   localparam logic [2:0] REG_ADDR        = 3'd6;
   localparam logic [2:0] REG_DATA        = 3'd7;

   localparam logic [13:0] ADDR_MASK = 14'h3FFF;

   // Classified command handed from the front part to the back part.
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] idx;
      logic [7:0] data;
   } cmd_type;
endpackage
`default_nettype wire

@@ rtl/tvu_front.sv @@
// Front part: accepts requests and keeps a two-entry command queue.
`default_nettype none
module tvu_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire logic [1:0]      req_type,
   input  wire logic [2:0]      req_reg_index,
   input  wire logic [7:0]      req_write_data,
   output logic                 cmd_valid,
   output tvu_pkg::cmd_type     cmd,
   input  wire logic            cmd_take
);
   tvu_pkg::cmd_type q_ff [2];
   tvu_pkg::cmd_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign busy      = (cnt_ff == 2'd2);
   assign push      = start && !busy;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[0];

   always_comb begin
      tvu_pkg::cmd_type c;
      c.kind = req_type;
      c.idx  = req_reg_index;
      c.data = req_write_data;
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (cmd_take && cmd_valid) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = c;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/tvu_back.sv @@
// Back part: register file, counters, video memory and pixel fetch sequencer.
`default_nettype none
module tvu_back #(
   parameter int VRAM_BYTES      = 16384,
   parameter int DOTS_PER_LINE   = 257,
   parameter int LINES_PER_FRAME = 262
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            mirror_vertical,
   input  wire logic            cmd_valid,
   input  wire tvu_pkg::cmd_type cmd,
   output logic                 cmd_take,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_read_data,
   output logic                 rsp_pixel_valid,
   output logic [1:0]           rsp_pixel_color,
   output logic [7:0]           rsp_pixel_x,
   output logic [7:0]           rsp_pixel_y,
   output logic                 rsp_nmi_pulse
);
   localparam int AW = $clog2(VRAM_BYTES);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_NAME  = 6'b000010,
      S_P0    = 6'b000100,
      S_PIX   = 6'b001000,
      S_RDATA = 6'b010000,
      S_MIRR  = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   logic [7:0] mem [VRAM_BYTES];
   logic [7:0] rd_ff;

   logic [7:0]  ctrl_ff, ctrl_in, mask_ff, mask_in, rbuf_ff, rbuf_in;
   logic [2:0]  stat_ff, stat_in;
   logic        tog_ff, tog_in;
   logic [14:0] tmp_ff, tmp_in;
   logic [13:0] vaddr_ff, vaddr_in;
   logic [8:0]  dot_ff, dot_in, line_ff, line_in;
   logic [7:0]  p0_ff, p0_in;
   logic [7:0]  mx_ff, mx_in, my_ff, my_in;
   logic [7:0]  wdat_ff, wdat_in;
   logic [13:0] waddr_ff, waddr_in;
   logic [13:0] rowa_ff, rowa_in;

   // Memory port controls.
   logic        we;
   logic [13:0] wa, ra;
   logic        ra_ok, wa_ok;
   logic        rok_ff;

   logic        o_v, o_pv, o_nmi;
   logic [7:0]  o_rd, o_x, o_y;
   logic [1:0]  o_col;

   logic [13:0] inc;
   logic [2:0]  sh;
   logic [13:0] row;
   logic [7:0]  rdv;

   assign inc = ctrl_ff[2] ? 14'd32 : 14'd1;
   assign sh  = 3'd7 - mx_ff[2:0];
   assign rdv = rok_ff ? rd_ff : 8'd0;
   assign row = (ctrl_ff[4] ? 14'h1000 : 14'h0) + {2'b0, rdv, 4'b0} + {11'd0, my_ff[2:0]};
   assign ra_ok = ({18'd0, ra} < 32'(VRAM_BYTES));
   assign wa_ok = ({18'd0, wa} < 32'(VRAM_BYTES));

   always_comb begin
      st_in = st_ff; ctrl_in = ctrl_ff; mask_in = mask_ff; rbuf_in = rbuf_ff;
      stat_in = stat_ff; tog_in = tog_ff; tmp_in = tmp_ff; vaddr_in = vaddr_ff;
      dot_in = dot_ff; line_in = line_ff; p0_in = p0_ff; mx_in = mx_ff; my_in = my_ff;
      wdat_in = wdat_ff; waddr_in = waddr_ff; rowa_in = rowa_ff;
      we = 1'b0; wa = vaddr_ff; ra = vaddr_ff;
      cmd_take = 1'b0;
      o_v = 1'b0; o_pv = 1'b0; o_nmi = 1'b0; o_rd = 8'd0; o_x = 8'd0; o_y = 8'd0;
      o_col = 2'd0;
      case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               case (cmd.kind)
                  tvu_pkg::REQ_TICK: begin
                     if ({23'd0, line_ff} >= LINES_PER_FRAME - 1) begin
                        o_v = 1'b1; line_in = 9'd0; dot_in = 9'd0;
                     end else begin
                        if (line_ff < 9'd240) begin
                           if (dot_ff == 9'd0) stat_in[2] = 1'b0;
                        end else if (line_ff == 9'd241 && dot_ff == 9'd1) begin
                           stat_in[2] = 1'b1;
                           o_nmi = ctrl_ff[7];
                        end
                        if (line_ff < 9'd240 && dot_ff < 9'd256) begin
                           mx_in = dot_ff[7:0]; my_in = line_ff[7:0];
                           ra = 14'h2000 + {2'b0, ctrl_ff[1:0], 10'd0}
                              + {9'd0, dot_ff[7:3]} + {4'd0, line_ff[7:3], 5'd0};
                           st_in = S_NAME;
                        end else begin
                           o_v = 1'b1;
                        end
                        if ({23'd0, dot_ff} + 1 >= DOTS_PER_LINE) begin
                           dot_in = 9'd0; line_in = line_ff + 9'd1;
                        end else begin
                           dot_in = dot_ff + 9'd1;
                        end
                     end
                  end
                  tvu_pkg::REQ_WRITE: begin
                     o_v = 1'b1;
                     case (cmd.idx)
                        tvu_pkg::REG_CTRL:   ctrl_in = cmd.data;
                        tvu_pkg::REG_MASK:   mask_in = cmd.data;
                        tvu_pkg::REG_STATUS: stat_in = cmd.data[7:5];
                        tvu_pkg::REG_SCROLL: begin
                           if (!tog_ff) tmp_in = {tmp_ff[14:5], cmd.data[7:3]};
                           else tmp_in = {cmd.data[2:0], tmp_ff[11:10],
                                          cmd.data[7:3], tmp_ff[4:0]};
                           tog_in = !tog_ff;
                        end
                        tvu_pkg::REG_ADDR: begin
                           if (!tog_ff) tmp_in = {1'b0, cmd.data[5:0], 8'd0};
                           else vaddr_in = {tmp_ff[13:8], cmd.data};
                           tog_in = !tog_ff;
                        end
                        tvu_pkg::REG_DATA: begin
                           we = 1'b1; wa = vaddr_ff;
                           vaddr_in = (vaddr_ff + inc) & tvu_pkg::ADDR_MASK;
                           wdat_in = cmd.data;
                           if (mirror_vertical && vaddr_ff >= 14'h2000 && vaddr_ff < 14'h3000) begin
                              waddr_in = vaddr_ff ^ 14'h0800;
                              o_v = 1'b0;
                              st_in = S_MIRR;
                           end
                        end
                        default: ;
                     endcase
                  end
                  tvu_pkg::REQ_READ: begin
                     o_v = 1'b1;
                     case (cmd.idx)
                        tvu_pkg::REG_CTRL: o_rd = ctrl_ff;
                        tvu_pkg::REG_MASK: o_rd = mask_ff;
                        tvu_pkg::REG_STATUS: begin
                           o_rd = {stat_ff, 5'd0}; stat_in[2] = 1'b0; tog_in = 1'b0;
                        end
                        tvu_pkg::REG_DATA: begin
                           o_v = 1'b0; ra = vaddr_ff;
                           vaddr_in = (vaddr_ff + inc) & tvu_pkg::ADDR_MASK;
                           st_in = S_RDATA;
                        end
                        default: ;
                     endcase
                  end
                  default: o_v = 1'b1;
               endcase
            end
         end
         S_NAME: begin
            ra = row; rowa_in = row; st_in = S_P0;
         end
         S_P0: begin
            p0_in = rdv; ra = rowa_ff + 14'd8; st_in = S_PIX;
         end
         S_PIX: begin
            o_v = 1'b1; o_pv = 1'b1; o_x = mx_ff; o_y = my_ff;
            o_col = {rdv[sh], p0_ff[sh]};
            st_in = S_IDLE;
         end
         S_RDATA: begin
            o_v = 1'b1; o_rd = rbuf_ff; rbuf_in = rdv; st_in = S_IDLE;
         end
         S_MIRR: begin
            we = 1'b1; wa = waddr_ff; o_v = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // The pattern row address is held from NAME, so P0 can fetch the high plane.
   always_ff @(posedge clock) begin
      if (we && wa_ok) mem[AW'(wa)] <= (st_ff == S_MIRR) ? wdat_ff : wdat_in;
      rd_ff  <= mem[AW'(ra)];
      rok_ff <= ra_ok;
   end

   always_ff @(posedge clock) begin
      p0_ff <= p0_in; mx_ff <= mx_in; my_ff <= my_in; rowa_ff <= rowa_in;
      wdat_ff <= wdat_in; waddr_ff <= waddr_in;
      rsp_read_data <= o_rd; rsp_pixel_valid <= o_pv; rsp_pixel_color <= o_col;
      rsp_pixel_x <= o_x; rsp_pixel_y <= o_y; rsp_nmi_pulse <= o_nmi;
      if (reset) begin
         st_ff <= S_IDLE; ctrl_ff <= 8'd0; mask_ff <= 8'd0; rbuf_ff <= 8'd0;
         stat_ff <= 3'd0; tog_ff <= 1'b0; tmp_ff <= 15'd0; vaddr_ff <= 14'd0;
         dot_ff <= 9'd0; line_ff <= 9'd0; rsp_valid <= 1'b0;
      end else begin
         st_ff <= st_in; ctrl_ff <= ctrl_in; mask_ff <= mask_in; rbuf_ff <= rbuf_in;
         stat_ff <= stat_in; tog_ff <= tog_in; tmp_ff <= tmp_in; vaddr_ff <= vaddr_in;
         dot_ff <= dot_in; line_ff <= line_in; rsp_valid <= o_v;
      end
   end
endmodule
`default_nettype wire

@@ rtl/tile_video_unit_with_register_port.sv @@
// Top level of the tile video unit with its register port.
`default_nettype none
// A request beat (tick, register write or register read) is taken when start
// is high and busy is low. Each request yields exactly one result beat, shown
// for one cycle with rsp_valid high; the receiver cannot stall it. A two-entry
// command queue parts the front from the back. Register accesses and
// non-rendering ticks end in the back part's IDLE state, a buffered data read
// passes RDATA, a mirrored data write MIRR, and a rendering tick NAME, P0 and
// PIX: its name byte and two pattern bytes come through the single read port
// of the video memory one after another. The video memory is not cleared at
// reset. mirror_vertical resets to 1 and is written through csr_write_enable.
module tile_video_unit_with_register_port #(
   parameter int VRAM_BYTES      = 16384,
   parameter int DOTS_PER_LINE   = 257,
   parameter int LINES_PER_FRAME = 262
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_type,
   input  wire logic [2:0] req_reg_index,
   input  wire logic [7:0] req_write_data,
   output logic            rsp_valid,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_pixel_valid,
   output logic [1:0]      rsp_pixel_color,
   output logic [7:0]      rsp_pixel_x,
   output logic [7:0]      rsp_pixel_y,
   output logic            rsp_nmi_pulse,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data
);
   logic mirror_ff;
   logic cmd_valid, cmd_take;
   tvu_pkg::cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_ff <= 1'b1;
      end else if (csr_write_enable) begin
         mirror_ff <= csr_write_data;
      end
   end

   tvu_front u_front (
      .clock, .reset, .start, .busy, .req_type, .req_reg_index, .req_write_data,
      .cmd_valid, .cmd, .cmd_take
   );

   tvu_back #(
      .VRAM_BYTES(VRAM_BYTES), .DOTS_PER_LINE(DOTS_PER_LINE),
      .LINES_PER_FRAME(LINES_PER_FRAME)
   ) u_back (
      .clock, .reset, .mirror_vertical(mirror_ff), .cmd_valid, .cmd, .cmd_take,
      .rsp_valid, .rsp_read_data, .rsp_pixel_valid, .rsp_pixel_color,
      .rsp_pixel_x, .rsp_pixel_y, .rsp_nmi_pulse
   );
endmodule
`default_nettype wire

@@ rtl/tvu_checker.sv @@
// Port checker for the tile video unit and its bind.
`default_nettype none
module tvu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic       rsp_pixel_valid,
   input wire logic       rsp_nmi_pulse,
   input wire logic [7:0] rsp_pixel_y,
   input wire logic [7:0] rsp_read_data
);
   a_pix_y: assert property (@(posedge clock) disable iff (reset)
      rsp_pixel_valid |-> rsp_pixel_y < 8'd240) else $error("pixel line out of range");
   a_pix_v: assert property (@(posedge clock) disable iff (reset)
      rsp_pixel_valid |-> rsp_valid) else $error("pixel without beat");
   a_nmi_v: assert property (@(posedge clock) disable iff (reset)
      rsp_nmi_pulse |-> rsp_valid && !rsp_pixel_valid) else $error("bad nmi beat");
   a_pix_rd: assert property (@(posedge clock) disable iff (reset)
      rsp_pixel_valid |-> rsp_read_data == 8'd0) else $error("read data on pixel");
   a_rst: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");
endmodule

bind tile_video_unit_with_register_port tvu_checker u_tvu_checker (
   .clock, .reset, .busy, .rsp_valid, .rsp_pixel_valid, .rsp_nmi_pulse,
   .rsp_pixel_y, .rsp_read_data
);
`default_nettype wire
